>>> hw/rtl/kgd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kgd_pkg: shared types and constants of the key gesture detector
// Sample and event payloads, the per-key state record, the gesture state
// codes, the event codes and the configuration register map.
// ---------------------------------------------------------------------------
package kgd_pkg;

    typedef struct packed {
        logic [1:0]  key_index;
        logic        pressed;
        logic [31:0] now_ms;
    } kgd_sample_t;

    typedef struct packed {
        logic [1:0] event_key;
        logic [1:0] event_kind;
    } kgd_event_t;

    typedef enum logic [3:0] {
        GS_IDLE        = 4'b0001,
        GS_WAIT_LONG   = 4'b0010,
        GS_WAIT_DOUBLE = 4'b0100,
        GS_REPEAT      = 4'b1000
    } kgd_gs_t;

    localparam logic [1:0] EV_SINGLE = 2'd0;
    localparam logic [1:0] EV_DOUBLE = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_REPEAT = 2'd3;

    localparam logic [1:0] CFG_DOUBLE_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS      = 2'd1;
    localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd2;

    localparam logic [15:0] DOUBLE_WINDOW_RESET   = 16'd300;
    localparam logic [15:0] LONG_PRESS_RESET      = 16'd2000;
    localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd200;

    typedef struct packed {
        kgd_gs_t     state;
        logic [31:0] entry_time;
        logic        level;
    } kgd_key_state_t;

    typedef struct packed {
        logic [15:0] double_window_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_interval_ms;
    } kgd_cfg_t;

    typedef struct packed {
        logic       fire;
        logic [1:0] kind;
    } kgd_hit_t;

endpackage

`default_nettype wire

>>> hw/rtl/kgd_fsm.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kgd_fsm: next-state logic for one key
// Finds the edges against the stored level, measures the wrapped elapsed
// time and advances the four-state gesture machine, flagging at most one
// event.
// ---------------------------------------------------------------------------
module kgd_fsm
    import kgd_pkg::*;
(
    input  kgd_key_state_t cur,
    input  logic           level,
    input  logic [31:0]    now_ms,
    input  kgd_cfg_t       cfg,
    output kgd_key_state_t nxt,
    output kgd_hit_t       hit
);

    logic        rise;
    logic        fall;
    logic [31:0] elapsed;
    logic        long_due;
    logic        double_due;
    logic        repeat_due;

    assign rise       = level & ~cur.level;
    assign fall       = ~level & cur.level;
    assign elapsed    = now_ms - cur.entry_time;
    assign long_due   = elapsed >= {16'd0, cfg.long_press_ms};
    assign double_due = elapsed >= {16'd0, cfg.double_window_ms};
    assign repeat_due = elapsed >= {16'd0, cfg.repeat_interval_ms};

    always_comb
    begin
        nxt       = cur;
        nxt.level = level;
        hit.fire  = 1'b0;
        hit.kind  = EV_SINGLE;
        unique case (cur.state)
            GS_WAIT_LONG:
            begin
                if (fall)
                begin
                    nxt.state      = GS_WAIT_DOUBLE;
                    nxt.entry_time = now_ms;
                end
                else if (level && long_due)
                begin
                    hit.fire       = 1'b1;
                    hit.kind       = EV_LONG;
                    nxt.state      = GS_REPEAT;
                    nxt.entry_time = now_ms;
                end
            end
            GS_WAIT_DOUBLE:
            begin
                if (rise)
                begin
                    hit.fire  = 1'b1;
                    hit.kind  = EV_DOUBLE;
                    nxt.state = GS_IDLE;
                end
                else if (double_due)
                begin
                    hit.fire  = 1'b1;
                    hit.kind  = EV_SINGLE;
                    nxt.state = GS_IDLE;
                end
            end
            GS_REPEAT:
            begin
                if (fall)
                begin
                    nxt.state = GS_IDLE;
                end
                else if (level && repeat_due)
                begin
                    hit.fire       = 1'b1;
                    hit.kind       = EV_REPEAT;
                    nxt.entry_time = now_ms;
                end
            end
            default:
            begin
                if (rise)
                begin
                    nxt.state      = GS_WAIT_LONG;
                    nxt.entry_time = now_ms;
                end
                else
                begin
                    nxt.state = GS_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/key_gesture_detector.sv
`default_nettype none
// A sample passes the input register and then the output register to gesture.
// Throughput: one sample per cycle unless the output stalls; the per-key state
// is read, updated and written back between the sample and event registers.
// Reset clears all keys to idle, not pressed, entry time zero, and loads the
// configuration defaults; the block takes samples right after reset.
// ---------------------------------------------------------------------------
// key_gesture_detector: single, double, long press and repeat detector
// Takes per-key scan samples and reports gesture events, one stage of
// per-key state update between an input register and an output register.
// ---------------------------------------------------------------------------
module key_gesture_detector
    import kgd_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  kgd_sample_t sample,
    output logic        gesture_valid,
    input  logic        gesture_ready,
    output kgd_event_t  gesture,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = (NUM_KEYS < 4) ? NUM_KEYS : 4;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    kgd_cfg_t       cfg_reg;
    kgd_key_state_t key_reg [DEPTH];
    kgd_sample_t    s1_reg;
    logic           s1_valid_reg;
    kgd_event_t     out_reg;
    logic           out_valid_reg;

    logic           advance;
    logic           key_ok;
    logic [IDX_W-1:0] idx;
    kgd_key_state_t cur;
    kgd_key_state_t key_next;
    kgd_hit_t       hit;

    assign advance      = s1_valid_reg & (~out_valid_reg | gesture_ready);
    assign sample_ready = ~s1_valid_reg | advance;
    assign key_ok       = int'(s1_reg.key_index) < DEPTH;
    assign idx          = key_ok ? IDX_W'(s1_reg.key_index) : '0;
    assign cur          = key_reg[idx];

    kgd_fsm u_fsm
    (
        .cur    (cur),
        .level  (s1_reg.pressed),
        .now_ms (s1_reg.now_ms),
        .cfg    (cfg_reg),
        .nxt    (key_next),
        .hit    (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_window_ms   <= DOUBLE_WINDOW_RESET;
            cfg_reg.long_press_ms      <= LONG_PRESS_RESET;
            cfg_reg.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            priority case (cfg_index)
                CFG_DOUBLE_WINDOW:   cfg_reg.double_window_ms   <= cfg_data;
                CFG_LONG_PRESS:      cfg_reg.long_press_ms      <= cfg_data;
                CFG_REPEAT_INTERVAL: cfg_reg.repeat_interval_ms <= cfg_data;
                default:             cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                key_reg[k].state      <= GS_IDLE;
                key_reg[k].entry_time <= '0;
                key_reg[k].level      <= 1'b0;
            end
        end
        else if (advance && key_ok)
        begin
            key_reg[idx] <= key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= hit.fire & key_ok;
            end
            else if (gesture_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            s1_reg <= sample;
        end
        if (advance && hit.fire && key_ok)
        begin
            out_reg.event_key  <= s1_reg.key_index;
            out_reg.event_kind <= hit.kind;
        end
    end

    assign gesture_valid = out_valid_reg;
    assign gesture       = out_reg;

    a_sample_lands: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> s1_valid_reg)
        else $error("Accepted sample did not reach the input register.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_reg))
        else $error("Stalled sample was lost or changed.");

    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(gesture_valid) |-> $past(advance))
        else $error("Event appeared without a state update.");

endmodule

`default_nettype wire
